// ----- rtl/core/fmpl_pkg.sv -----
// fmpl_pkg: shared types and constants for the fuel map pulse lookup
// no dependencies
package fmpl_pkg;
  localparam int TableRows = 16;
  localparam int TableCols = 16;
  localparam int EntryBits = 32;
  localparam int FracBits  = 16;
  localparam int RowBits   = $clog2(TableRows);
  localparam int ColBits   = $clog2(TableCols);
  localparam int AddrBits  = RowBits + ColBits;
  localparam int CoordBits = RowBits + FracBits + 1;
  localparam int AccBits   = 48;
  localparam logic [17:0] PulseLimit = 18'd250000;
  localparam logic [12:0] StartNum   = 13'd5734;

  localparam logic [2:0] REG_MIN_MAP    = 3'd0;
  localparam logic [2:0] REG_MAX_MAP    = 3'd1;
  localparam logic [2:0] REG_MIN_RPM    = 3'd2;
  localparam logic [2:0] REG_MAX_RPM    = 3'd3;
  localparam logic [2:0] REG_OPEN_TIME  = 3'd4;
  localparam logic [2:0] REG_GAIN_Q8    = 3'd5;
  localparam logic [2:0] REG_START_REVS = 3'd6;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;
endpackage

// ----- rtl/core/fmpl_div.sv -----
// fmpl_div: shared restoring divider, one quotient bit per cycle
// depends on fmpl_pkg
module fmpl_div import fmpl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [47:0] quo, den;
  logic [48:0] rem;
  logic [5:0]  cnt;
  logic        busy, done;
  logic [48:0] trial;

  assign trial = {rem[47:0], quo[47]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd47;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
    if (req.start) begin
      quo <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
endmodule

// ----- rtl/core/fmpl_table.sv -----
// fmpl_table: base pulse table memory, one write and one registered read port
// depends on fmpl_pkg
module fmpl_table import fmpl_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AddrBits-1:0]  waddr,
  input  logic [EntryBits-1:0] wdata,
  input  logic [AddrBits-1:0]  raddr,
  output logic [EntryBits-1:0] rdata
);
  logic [EntryBits-1:0] mem [TableRows*TableCols];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/fuel_map_pulse_lookup.sv -----
// fuel_map_pulse_lookup: top level, sequencer around a shared divider and multiplier
// depends on fmpl_pkg, fmpl_div, fmpl_table
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata, tuser = cmd
// m_axis    out  m_axis_tvalid/tready    tdata = pulse_time, was_clamped
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// a write is taken in S_IDLE and the block stays ready for the next request; a lookup raises
// m_axis_tvalid after the 48-step serial divider has run for the two axes (each skipped if
// the value is at or below its minimum or the range is empty) and for the temperature
// synchronous reset clears control and sets the config registers to defaults; table contents undefined
// the result register holds while m_axis_tready is low; no new request until taken
module fuel_map_pulse_lookup import fmpl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [103:0] s_axis_tdata, // row, col, entry_value, map_value, rpm, air_temp, rev_count
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // pulse_time, was_clamped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DY = 4'd1, S_DYW = 4'd2, S_DX = 4'd3,
    S_DXW = 4'd4, S_RD = 4'd5, S_MUL = 4'd6, S_TDIV = 4'd7, S_TW = 4'd8,
    S_ST = 4'd9, S_GN = 4'd10, S_FIN = 4'd11, S_OUT = 4'd12;

  logic [3:0]  state;
  logic [15:0] min_map, max_map, min_rpm, max_rpm, open_time, start_revs;
  logic [9:0]  gain_q8;
  logic [15:0] mapv, rpmv, revs;
  logic [9:0]  temp;
  logic [CoordBits-1:0] yq, xq;
  logic [2:0]  step;
  logic [EntryBits-1:0] e0, e1, e2;
  logic [AccBits-1:0] r0, acc, t;
  logic        edge_sel;
  logic [17:0] pulse;
  logic        clamp;
  logic        we;
  logic [AddrBits-1:0] raddr;
  logic [EntryBits-1:0] rdata;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [3:0]  wrow, wcol;
  assign wrow = s_axis_tdata[3:0];
  assign wcol = s_axis_tdata[7:4];

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign we = accept && (s_axis_tuser == CMD_WRITE);

  fmpl_table u_tab (.clk, .we, .waddr({wrow, wcol}), .wdata(s_axis_tdata[39:8]),
    .raddr, .rdata);
  fmpl_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  // axis request setup
  logic        ysel;
  logic [15:0] av, alo, ahi;
  assign ysel = (state == S_DY);
  assign av  = ysel ? mapv : rpmv;
  assign alo = ysel ? min_map : min_rpm;
  assign ahi = ysel ? max_map : max_rpm;

  always_comb begin
    dreq = '0;
    unique case (state)
      S_DY, S_DX: begin
        dreq.start = (av > alo) && (ahi > alo);
        dreq.num = AccBits'(({32'd0, av - alo} * (ysel ? 48'(TableRows - 1)
                   : 48'(TableCols - 1))) << FracBits);
        dreq.den = {32'd0, ahi - alo};
      end
      S_TDIV: begin
        dreq.start = 1'b1;
        dreq.num = acc;
        dreq.den = {38'd0, (temp == 10'd0) ? 10'd1 : temp};
      end
      default: ;
    endcase
  end

  logic [RowBits-1:0] ri;
  logic [ColBits-1:0] ci;
  logic [FracBits-1:0] fy, fx;
  assign ri = yq[FracBits +: RowBits];
  assign ci = xq[FracBits +: ColBits];
  assign fy = yq[FracBits-1:0];
  assign fx = xq[FracBits-1:0];
  assign edge_sel = (yq[CoordBits-1:FracBits] >= (CoordBits-FracBits)'(TableRows - 1))
                 || (xq[CoordBits-1:FracBits] >= (CoordBits-FracBits)'(TableCols - 1));

  always_comb begin
    raddr = {ri, ci};
    unique case (step) inside
      3'd1: raddr = {ri, ci + ColBits'(1)};
      3'd2: raddr = {ri + RowBits'(1), ci};
      3'd3, 3'd4: raddr = {ri + RowBits'(1), ci + ColBits'(1)};
      default: ;
    endcase
  end

  // shared fractional multiplier: floor(a*w/2^FracBits)
  logic [AccBits-1:0] ma;
  logic [FracBits:0]  mw;
  logic [AccBits-1:0] mprod;
  logic [AccBits+FracBits:0] mfull;
  assign mfull = {{(FracBits+1){1'b0}}, ma} * {{AccBits{1'b0}}, mw};
  assign mprod = mfull[FracBits +: AccBits];
  logic [FracBits:0] one;
  assign one = (FracBits+1)'(1) << FracBits;

  always_comb begin
    ma = '0;
    mw = '0;
    case (step)
      3'd2: begin ma = AccBits'(e0); mw = one - {1'b0, fx}; end
      3'd3: begin ma = AccBits'(e1); mw = {1'b0, fx}; end
      3'd4: begin ma = AccBits'(e2); mw = one - {1'b0, fx}; end
      3'd5: begin ma = AccBits'(rdata); mw = {1'b0, fx}; end
      3'd6: begin ma = r0; mw = one - {1'b0, fy}; end
      3'd7: begin ma = acc; mw = {1'b0, fy}; end
      default: ;
    endcase
  end

  logic [AccBits+12:0] st_prod;
  logic [AccBits+9:0]  gn_prod;
  logic [AccBits:0]    psum;
  assign st_prod = t * StartNum;
  assign gn_prod = t * gain_q8;
  assign psum = {1'b0, t} + (AccBits+1)'(open_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      m_axis_tvalid <= 1'b0;
      min_map <= '0; max_map <= 16'hFFFF; min_rpm <= '0; max_rpm <= 16'hFFFF;
      open_time <= '0; gain_q8 <= 10'd256; start_revs <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_MAP:    min_map <= cfg_data;
          REG_MAX_MAP:    max_map <= cfg_data;
          REG_MIN_RPM:    min_rpm <= cfg_data;
          REG_MAX_RPM:    max_rpm <= cfg_data;
          REG_OPEN_TIME:  open_time <= cfg_data;
          REG_GAIN_Q8:    gain_q8 <= cfg_data[9:0];
          REG_START_REVS: start_revs <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (accept && s_axis_tuser == CMD_LOOKUP) begin
          mapv <= s_axis_tdata[55:40];
          rpmv <= s_axis_tdata[71:56];
          temp <= s_axis_tdata[81:72];
          revs <= s_axis_tdata[97:82];
          state <= S_DY;
        end
        S_DY: state <= S_DYW;
        S_DYW: if (!drsp.busy) begin
          yq <= (mapv <= min_map) ? '0 : (max_map <= min_map) ?
                CoordBits'(TableRows - 1) << FracBits :
                ((drsp.quo > AccBits'(CoordBits'(TableRows - 1) << FracBits)) ?
                CoordBits'(TableRows - 1) << FracBits : drsp.quo[CoordBits-1:0]);
          state <= S_DX;
        end
        S_DX: state <= S_DXW;
        S_DXW: if (!drsp.busy) begin
          xq <= (rpmv <= min_rpm) ? '0 : (max_rpm <= min_rpm) ?
                CoordBits'(TableCols - 1) << FracBits :
                ((drsp.quo > AccBits'(CoordBits'(TableCols - 1) << FracBits)) ?
                CoordBits'(TableCols - 1) << FracBits : drsp.quo[CoordBits-1:0]);
          step <= '0;
          state <= S_RD;
        end
        S_RD: begin
          step <= step + 3'd1;
          if (step == 3'd1) begin
            e0 <= rdata;
            if (edge_sel) begin
              acc <= AccBits'(rdata);
              state <= S_TDIV;
            end
          end
          if (step == 3'd2) e1 <= rdata;
          if (step == 3'd3) e2 <= rdata;
          if (step == 3'd4) state <= S_MUL;
        end
        // far corner term first while it sits on the read port, then both rows
        S_MUL: begin
          case (step)
            3'd5: begin acc <= mprod; step <= 3'd2; end
            3'd2: begin r0 <= mprod; step <= 3'd3; end
            3'd3: begin r0 <= r0 + mprod; step <= 3'd4; end
            3'd4: begin acc <= acc + mprod; step <= 3'd6; end
            3'd6: begin t <= mprod; step <= 3'd7; end
            3'd7: begin acc <= t + mprod; state <= S_TDIV; end
            default: ;
          endcase
        end
        S_TDIV: state <= S_TW;
        S_TW: if (!drsp.busy) begin
          t <= drsp.quo;
          state <= S_ST;
        end
        S_ST: begin
          if (revs <= start_revs) t <= st_prod[12 +: AccBits];
          state <= S_GN;
        end
        S_GN: begin
          t <= gn_prod[8 +: AccBits];
          state <= S_FIN;
        end
        S_FIN: begin
          clamp <= psum > (AccBits+1)'(PulseLimit);
          pulse <= (psum > (AccBits+1)'(PulseLimit)) ? PulseLimit : psum[17:0];
          m_axis_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {5'd0, clamp, pulse};

  logic unused;
  assign unused = ^s_axis_tdata[103:98];

  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == S_OUT)) else $error("valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_pulse_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pulse <= PulseLimit)) else $error("pulse above limit");
endmodule

// ----- test/tb_fuel_map_pulse_lookup.sv -----
// testbench for fuel_map_pulse_lookup: table writes, directed and random lookups
// checked against an in-bench pulse predictor or typed expected values; depends on fmpl_pkg and the rtl
`timescale 1ns / 100ps

module tb_fuel_map_pulse_lookup;
  import fmpl_pkg::*;

  typedef struct {
    logic        cmd;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] entry;
    logic [15:0] map_v;
    logic [15:0] rpm;
    logic [9:0]  temp;
    logic [15:0] revs;
    logic        typed;
    logic [17:0] pulse;
    logic        clamp;
  } request_t;

  typedef struct {
    logic [17:0] pulse;
    logic        clamp;
  } pulse_t;

  typedef logic [15:0] reg_set_t [7];

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;  // row, col, entry_value, map_value, rpm, air_temp, rev_count
  logic         s_axis_tuser;  // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [23:0]  m_axis_tdata;  // pulse_time, was_clamped
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  logic [31:0] fuel_table [TableRows*TableCols];
  logic [15:0] min_map_r, max_map_r, min_rpm_r, max_rpm_r, open_time_r, start_revs_r;
  logic [9:0]  gain_r;
  pulse_t      pulse_q [$];
  int          mismatches;
  int          quiet_cycles;
  bit          long_hold;
  bit          no_idle;

  fuel_map_pulse_lookup DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned axis_coord(logic [15:0] v, logic [15:0] lo,
                                                 logic [15:0] hi, int n);
    longint unsigned top, q;
    top = longint'(n - 1) << FracBits;
    if (v <= lo) return 0;
    if (hi <= lo) return top;
    q = ((longint'(v - lo) * longint'(n - 1)) << FracBits) / longint'(hi - lo);
    return (q > top) ? top : q;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned f);
    return ((a * ((64'd1 << FracBits) - f)) >> FracBits) + ((b * f) >> FracBits);
  endfunction

  function automatic pulse_t predict_pulse(request_t r);
    longint unsigned yq, xq, fy, fx, base, t, p, r0, r1;
    int ri, ci;
    pulse_t res;
    yq = axis_coord(r.map_v, min_map_r, max_map_r, TableRows);
    xq = axis_coord(r.rpm, min_rpm_r, max_rpm_r, TableCols);
    ri = int'(yq >> FracBits);
    ci = int'(xq >> FracBits);
    fy = yq & ((64'd1 << FracBits) - 1);
    fx = xq & ((64'd1 << FracBits) - 1);
    if (ri < TableRows - 1 && ci < TableCols - 1) begin
      r0 = blend(fuel_table[ri*TableCols+ci], fuel_table[ri*TableCols+ci+1], fx);
      r1 = blend(fuel_table[(ri+1)*TableCols+ci], fuel_table[(ri+1)*TableCols+ci+1], fx);
      base = blend(r0, r1, fy);
    end else begin
      base = fuel_table[ri*TableCols+ci];
    end
    t = base / ((r.temp == 0) ? 64'd1 : longint'(r.temp));
    if (r.revs <= start_revs_r) t = (t * StartNum) >> 12;
    t = (t * gain_r) >> 8;
    p = t + open_time_r;
    res.clamp = (p > PulseLimit);
    res.pulse = res.clamp ? PulseLimit : p[17:0];
    return res;
  endfunction

  task automatic send_request(request_t r);
    int gap;
    pulse_t want;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= {6'd0, r.revs, r.temp, r.rpm, r.map_v, r.entry, r.col, r.row};
    do @(posedge clk); while (!s_axis_tready);
    if (r.cmd == CMD_WRITE) begin
      fuel_table[{r.row, r.col}] = r.entry;
    end else begin
      want = predict_pulse(r);
      if (r.typed) begin
        want.pulse = r.pulse;
        want.clamp = r.clamp;
      end
      pulse_q.push_back(want);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_MAP:    min_map_r = val;
      REG_MAX_MAP:    max_map_r = val;
      REG_MIN_RPM:    min_rpm_r = val;
      REG_MAX_RPM:    max_rpm_r = val;
      REG_OPEN_TIME:  open_time_r = val;
      REG_GAIN_Q8:    gain_r = val[9:0];
      REG_START_REVS: start_revs_r = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(reg_set_t v);
    while (pulse_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    write_reg(REG_MIN_MAP, v[0]);
    write_reg(REG_MAX_MAP, v[1]);
    write_reg(REG_MIN_RPM, v[2]);
    write_reg(REG_MAX_RPM, v[3]);
    write_reg(REG_OPEN_TIME, v[4]);
    write_reg(REG_GAIN_Q8, v[5]);
    write_reg(REG_START_REVS, v[6]);
    // unknown index, must be ignored
    write_reg(3'd7, 16'hFFFF);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] near(logic [15:0] a, logic [15:0] b);
    case ($urandom_range(0, 5))
      0: return a;
      1: return b;
      2: return a + 16'($urandom_range(0, 3));
      3: return b - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.cmd   = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_LOOKUP;
    r.row   = 4'($urandom_range(0, 15));
    r.col   = 4'($urandom_range(0, 15));
    r.entry = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom();
    r.map_v = near(min_map_r, max_map_r);
    r.rpm   = near(min_rpm_r, max_rpm_r);
    r.temp  = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
    r.revs  = near(16'd0, start_revs_r);
    r.typed = 1'b0;
    r.pulse = '0;
    r.clamp = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // response side
  initial begin
    int w;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      w = no_idle ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pulse_q.size() == 0) begin
        $display("unexpected result %0d at %0t", m_axis_tdata[17:0], $realtime);
        mismatches++;
      end else begin
        if (m_axis_tdata[17:0] !== pulse_q[0].pulse)
          report_mismatch("pulse_time", m_axis_tdata[17:0], pulse_q[0].pulse);
        if (m_axis_tdata[18] !== pulse_q[0].clamp)
          report_mismatch("was_clamped", m_axis_tdata[18], pulse_q[0].clamp);
        void'(pulse_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == 5000) begin
      $display("tb_fuel_map_pulse_lookup NOT OK");
      $finish;
    end
  end

  initial begin
    request_t directed [12];
    reg_set_t phases [6];
    request_t r;
    long_hold     = 1'b0;
    no_idle       = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_WRITE;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MIN_MAP;
    cfg_data      = '0;
    min_map_r = 0; max_map_r = 16'hFFFF; min_rpm_r = 0; max_rpm_r = 16'hFFFF;
    open_time_r = 0; gain_r = 10'd256; start_revs_r = 0;

    //             cmd         row   col   entry          map       rpm       temp  revs
    directed[0]  = '{CMD_WRITE, 4'd0, 4'd0, 32'd1000, 16'd0, 16'd0, 10'd0, 16'd0, 0, 0, 0};
    directed[1]  = '{CMD_LOOKUP, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 10'd1, 16'd1,
                     1, 18'd1000, 1'b0};
    // zero temperature divides as one
    directed[2]  = '{CMD_LOOKUP, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 10'd0, 16'd9,
                     1, 18'd1000, 1'b0};
    directed[3]  = '{CMD_WRITE, 4'd15, 4'd15, 32'hFFFF_FFFF, 16'd0, 16'd0, 10'd0, 16'd0,
                     0, 0, 0};
    directed[4]  = '{CMD_LOOKUP, 4'd0, 4'd0, 32'd0, 16'hFFFF, 16'hFFFF, 10'd0, 16'd1,
                     1, 18'd250000, 1'b1};
    directed[5]  = '{CMD_LOOKUP, 4'd0, 4'd0, 32'd0, 16'hFFFF, 16'hFFFF, 10'd1023, 16'd0,
                     1, 18'd250000, 1'b1};
    directed[6]  = '{CMD_WRITE, 4'd15, 4'd0, 32'd777777, 16'd0, 16'd0, 10'd0, 16'd0, 0, 0, 0};
    directed[7]  = '{CMD_LOOKUP, 4'd0, 4'd0, 32'd0, 16'hFFFF, 16'd0, 10'd3, 16'hFFFF, 0, 0, 0};
    directed[8]  = '{CMD_WRITE, 4'd0, 4'd15, 32'd0, 16'd0, 16'd0, 10'd0, 16'd0, 0, 0, 0};
    directed[9]  = '{CMD_LOOKUP, 4'd0, 4'd0, 32'd0, 16'd0, 16'hFFFF, 10'd2, 16'd5, 0, 0, 0};
    directed[10] = '{CMD_LOOKUP, 4'd0, 4'd0, 32'd0, 16'd32768, 16'd12345, 10'd300, 16'd0,
                     0, 0, 0};
    directed[11] = '{CMD_LOOKUP, 4'd0, 4'd0, 32'd0, 16'd4369, 16'd61000, 10'd1, 16'd2,
                     0, 0, 0};

    phases[0] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd256, 16'd0};
    phases[1] = '{16'd1000, 16'd40000, 16'd500, 16'd9000, 16'd800, 16'd300, 16'd200};
    phases[2] = '{16'd30000, 16'd30000, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1023, 16'hFFFF};
    phases[3] = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};
    phases[4] = '{16'd0, 16'd1, 16'd0, 16'd1, 16'd1200, 16'd128, 16'd1000};
    phases[5] = '{16'd2000, 16'd60000, 16'd300, 16'd7000, 16'd500, 16'd256, 16'd50};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table so no lookup reads an unwritten entry
    for (int i = 0; i < TableRows*TableCols; i++) begin
      r = random_request();
      r.cmd = CMD_WRITE;
      r.row = 4'(i / TableCols);
      r.col = 4'(i % TableCols);
      send_request(r);
    end
    foreach (directed[i]) send_request(directed[i]);

    for (int ph = 0; ph < 6; ph++) begin
      s_axis_tvalid <= 1'b0;
      load_regs(phases[ph]);
      if (ph == 1) long_hold = 1'b1;
      no_idle = (ph == 5);
      for (int n = 0; n < 72; n++) send_request(random_request());
    end
    s_axis_tvalid <= 1'b0;

    while (pulse_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("tb_fuel_map_pulse_lookup OK");
    else
      $display("tb_fuel_map_pulse_lookup NOT OK");
    $finish;
  end
endmodule
